### hdl/assert_macros.svh
// assertion helpers shared by the tracker rtl
// used by the modules that check their own control logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tht_pkg.sv
// types, constants and helpers of the tcp handshake latency tracker
// no dependencies; imported by every tracker module
package tht_pkg;

  localparam int TABLE_DEPTH  = 1024;
  localparam int WINDOW_DEPTH = 1024;
  localparam int TIDX_W = $clog2(TABLE_DEPTH);
  localparam int TCNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int WIDX_W = $clog2(WINDOW_DEPTH);
  localparam int WCNT_W = $clog2(WINDOW_DEPTH + 1);

  localparam logic [3:0] ST_ESTABLISHED = 4'd1;
  localparam logic [3:0] ST_SYN_SENT    = 4'd2;
  localparam logic [3:0] ST_CLOSE       = 4'd7;

  localparam logic [31:0] WINDOW_US_RESET = 32'd60000000;

  typedef enum logic [2:0] {
    KIND_START     = 3'd0,
    KIND_SUCCESS   = 3'd1,
    KIND_FAILURE   = 3'd2,
    KIND_UNMATCHED = 3'd3,
    KIND_IGNORED   = 3'd4,
    KIND_AGED      = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    OP_AGE,
    OP_START,
    OP_TERM_OK,
    OP_TERM_FAIL,
    OP_IGNORE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] addrs;
    logic [31:0] ports;
    logic [47:0] now;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] addrs;
    logic [31:0] ports;
    logic [47:0] lat;
    logic [31:0] att;
    logic [31:0] suc;
    logic [31:0] fail;
    logic [31:0] unm;
    logic        ovf;
  } res_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] addrs;
    logic [31:0] ports;
    logic [47:0] start;
  } pend_ent_t;

  typedef struct packed {
    logic        ok;
    logic [47:0] stamp;
  } win_ent_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [31:0] floor_dec(input logic [31:0] v);
    return (v == 32'd0) ? v : v - 32'd1;
  endfunction

endpackage

### hdl/tht_front.sv
// front end: accepts input beats, classifies them and queues commands
// depends on tht_pkg
module tht_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic           hold_i,
  input  logic           req_type_i,
  input  logic [31:0]    src_addr_i,
  input  logic [31:0]    dst_addr_i,
  input  logic [15:0]    src_port_i,
  input  logic [15:0]    dst_port_i,
  input  logic [3:0]     old_state_i,
  input  logic [3:0]     new_state_i,
  input  logic [47:0]    time_us_i,
  output logic           cmd_vld_o,
  output tht_pkg::cmd_t  cmd_o,
  input  logic           cmd_pop_i
);
  import tht_pkg::*;

  cmd_t       q_mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       acc;

  always_comb begin
    cls.addrs = {src_addr_i, dst_addr_i};
    cls.ports = {src_port_i, dst_port_i};
    cls.now   = time_us_i;
    if (req_type_i) begin
      cls.op = OP_AGE;
    end else if (new_state_i == ST_SYN_SENT && old_state_i != ST_SYN_SENT) begin
      cls.op = OP_START;
    end else if (new_state_i == ST_ESTABLISHED) begin
      cls.op = OP_TERM_OK;
    end else if (new_state_i == ST_CLOSE) begin
      cls.op = OP_TERM_FAIL;
    end else begin
      cls.op = OP_IGNORE;
    end
  end

  assign full      = (cnt_q == 2'd2) || hold_i;
  assign acc       = push && !full;
  assign cmd_vld_o = (cnt_q != 2'd0);
  assign cmd_o     = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (acc) begin
      q_mem_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (acc) begin
        wp_q <= ~wp_q;
      end
      if (cmd_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, cmd_pop_i};
    end
  end

endmodule

### hdl/tht_back.sv
// back end: pending table scan, window ring and counters, result register
// depends on tht_pkg and assert_macros.svh
`include "assert_macros.svh"
module tht_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    window_us_i,
  input  logic           cmd_vld_i,
  input  tht_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  output logic           init_busy_o,
  output logic           res_vld_o,
  output tht_pkg::res_t  res_o,
  input  logic           res_pop_i
);
  import tht_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN, S_TAIL, S_EXEC, S_CLR, S_CLR_PUT,
    S_WIN_RD, S_WIN_PUT, S_AGE_RD, S_AGE_CHK, S_FIN
  } bst_e;

  bst_e              st_q, st_d;
  logic [TCNT_W-1:0] cnt_q, cnt_d;
  cmd_t              cmd_q, cmd_d;
  logic              prd_vld_q, prd_vld_d;
  logic [TIDX_W-1:0] prd_idx_q, prd_idx_d;
  logic              found_q, found_d, free_found_q, free_found_d;
  logic [TIDX_W-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [47:0]       hit_start_q, hit_start_d;
  logic [TCNT_W-1:0] used_q, used_d;
  logic [WIDX_W-1:0] head_q, head_d;
  logic [WCNT_W-1:0] fill_q, fill_d;
  logic [31:0]       att_q, att_d, suc_q, suc_d, fail_q, fail_d, unm_q, unm_d;
  kind_e             kind_q, kind_d;
  logic [47:0]       lat_q, lat_d;
  logic              ovf_q, ovf_d, show_q, show_d;
  logic              res_vld_q, res_vld_d;
  res_t              res_q, res_d;

  // pending table and window ring memories
  pend_ent_t         pend_mem [TABLE_DEPTH];
  pend_ent_t         prd_q, pwd;
  logic              pwe;
  logic [TIDX_W-1:0] pwa, pra;
  win_ent_t          win_mem [WINDOW_DEPTH];
  win_ent_t          wrd_q, wwd;
  logic              wwe;
  logic [WIDX_W-1:0] wwa, wra;

  always_ff @(posedge clk_i) begin
    if (pwe) begin
      pend_mem[pwa] <= pwd;
    end
    prd_q <= pend_mem[pra];
  end

  always_ff @(posedge clk_i) begin
    if (wwe) begin
      win_mem[wwa] <= wwd;
    end
    wrd_q <= win_mem[wra];
  end

  logic              hit, free;
  logic [WIDX_W-1:0] h_nx;
  logic [WCNT_W-1:0] f_nx;
  logic [WCNT_W:0]   slot_sum;
  logic [47:0]       age;

  assign hit  = prd_vld_q && prd_q.valid && prd_q.addrs == cmd_q.addrs
                && prd_q.ports == cmd_q.ports;
  assign free = prd_vld_q && !prd_q.valid;
  assign age  = cmd_q.now - wrd_q.stamp;

  function automatic logic [WIDX_W-1:0] wrap_inc(input logic [WIDX_W-1:0] v);
    return (v == WIDX_W'(WINDOW_DEPTH - 1)) ? '0 : v + WIDX_W'(1);
  endfunction

  always_comb begin
    st_d         = st_q;
    cnt_d        = cnt_q;
    cmd_d        = cmd_q;
    prd_vld_d    = 1'b0;
    found_d      = found_q;
    free_found_d = free_found_q;
    hit_idx_d    = hit_idx_q;
    free_idx_d   = free_idx_q;
    hit_start_d  = hit_start_q;
    used_d       = used_q;
    head_d       = head_q;
    fill_d       = fill_q;
    att_d        = att_q;
    suc_d        = suc_q;
    fail_d       = fail_q;
    unm_d        = unm_q;
    kind_d       = kind_q;
    lat_d        = lat_q;
    ovf_d        = ovf_q;
    show_d       = show_q;
    res_vld_d    = res_vld_q && !res_pop_i;
    res_d        = res_q;
    cmd_pop_o    = 1'b0;
    pwe          = 1'b0;
    pwa          = cnt_q[TIDX_W-1:0];
    pwd          = '0;
    pra          = cnt_q[TIDX_W-1:0];
    prd_idx_d    = pra;
    wwe          = 1'b0;
    wwa          = '0;
    wwd          = '0;
    wra          = head_q;
    h_nx         = head_q;
    f_nx         = fill_q;
    slot_sum     = '0;

    // scan results arrive in the cycle after the read
    if (hit && !found_q) begin
      found_d     = 1'b1;
      hit_idx_d   = prd_idx_q;
      hit_start_d = prd_q.start;
    end
    if (free && !free_found_q) begin
      free_found_d = 1'b1;
      free_idx_d   = prd_idx_q;
    end

    case (st_q)
      S_INIT: begin
        pwe   = 1'b1;
        cnt_d = cnt_q + TCNT_W'(1);
        if (cnt_q == TCNT_W'(TABLE_DEPTH - 1)) begin
          cnt_d = '0;
          st_d  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_vld_i && !res_vld_q) begin
          cmd_pop_o    = 1'b1;
          cmd_d        = cmd_i;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          cnt_d        = '0;
          lat_d        = '0;
          ovf_d        = 1'b0;
          show_d       = 1'b0;
          case (cmd_i.op)
            OP_AGE: begin
              kind_d = KIND_AGED;
              st_d   = S_AGE_RD;
            end
            OP_IGNORE: begin
              kind_d = KIND_IGNORED;
              st_d   = S_FIN;
            end
            default: begin
              kind_d = KIND_IGNORED;
              st_d   = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        prd_vld_d = 1'b1;
        cnt_d     = cnt_q + TCNT_W'(1);
        if (cnt_q == TCNT_W'(TABLE_DEPTH - 1)) begin
          st_d = S_TAIL;
        end
      end
      S_TAIL: begin
        st_d = S_EXEC;
      end
      S_EXEC: begin
        case (cmd_q.op)
          OP_START: begin
            att_d  = sat_inc(att_q);
            kind_d = KIND_START;
            pwd    = '{valid: 1'b1, addrs: cmd_q.addrs, ports: cmd_q.ports,
                       start: cmd_q.now};
            st_d   = S_FIN;
            if (found_q) begin
              pwe = 1'b1;
              pwa = hit_idx_q;
            end else if (used_q == TCNT_W'(TABLE_DEPTH)) begin
              ovf_d = 1'b1;
              cnt_d = '0;
              st_d  = S_CLR;
            end else begin
              pwe    = 1'b1;
              pwa    = free_idx_q;
              used_d = used_q + TCNT_W'(1);
            end
          end
          OP_TERM_OK, OP_TERM_FAIL: begin
            if (!found_q) begin
              unm_d  = sat_inc(unm_q);
              kind_d = KIND_UNMATCHED;
              st_d   = S_FIN;
            end else begin
              pwe    = 1'b1;
              pwa    = hit_idx_q;
              used_d = (used_q == '0) ? used_q : used_q - TCNT_W'(1);
              lat_d  = (cmd_q.now >= hit_start_q) ? cmd_q.now - hit_start_q : '0;
              show_d = 1'b1;
              if (cmd_q.op == OP_TERM_OK) begin
                suc_d  = sat_inc(suc_q);
                kind_d = KIND_SUCCESS;
              end else begin
                fail_d = sat_inc(fail_q);
                kind_d = KIND_FAILURE;
              end
              st_d = S_WIN_RD;
            end
          end
          default: begin
            st_d = S_FIN;
          end
        endcase
      end
      S_CLR: begin
        pwe   = 1'b1;
        cnt_d = cnt_q + TCNT_W'(1);
        if (cnt_q == TCNT_W'(TABLE_DEPTH - 1)) begin
          st_d = S_CLR_PUT;
        end
      end
      S_CLR_PUT: begin
        pwe    = 1'b1;
        pwa    = '0;
        pwd    = '{valid: 1'b1, addrs: cmd_q.addrs, ports: cmd_q.ports,
                   start: cmd_q.now};
        used_d = TCNT_W'(1);
        st_d   = S_FIN;
      end
      S_WIN_RD: begin
        st_d = S_WIN_PUT;
      end
      S_WIN_PUT: begin
        // a full ring first ages out its oldest entry
        if (fill_q == WCNT_W'(WINDOW_DEPTH)) begin
          if (wrd_q.ok) begin
            suc_d = floor_dec(suc_q);
          end else begin
            fail_d = floor_dec(fail_q);
          end
          h_nx = wrap_inc(head_q);
          f_nx = fill_q - WCNT_W'(1);
        end
        slot_sum = {{(WCNT_W + 1 - WIDX_W){1'b0}}, h_nx} + {1'b0, f_nx};
        if (slot_sum >= (WCNT_W + 1)'(WINDOW_DEPTH)) begin
          slot_sum = slot_sum - (WCNT_W + 1)'(WINDOW_DEPTH);
        end
        wwe    = 1'b1;
        wwa    = slot_sum[WIDX_W-1:0];
        wwd    = '{ok: (cmd_q.op == OP_TERM_OK), stamp: cmd_q.now};
        head_d = h_nx;
        fill_d = f_nx + WCNT_W'(1);
        st_d   = S_FIN;
      end
      S_AGE_RD: begin
        st_d = (fill_q == '0) ? S_FIN : S_AGE_CHK;
      end
      S_AGE_CHK: begin
        if (cmd_q.now >= wrd_q.stamp && age > {16'd0, window_us_i}) begin
          if (wrd_q.ok) begin
            suc_d = floor_dec(suc_q);
          end else begin
            fail_d = floor_dec(fail_q);
          end
          head_d = wrap_inc(head_q);
          fill_d = fill_q - WCNT_W'(1);
          st_d   = S_AGE_RD;
        end else begin
          st_d = S_FIN;
        end
      end
      S_FIN: begin
        res_vld_d  = 1'b1;
        res_d.kind  = kind_q;
        res_d.addrs = show_q ? cmd_q.addrs : '0;
        res_d.ports = show_q ? cmd_q.ports : '0;
        res_d.lat   = lat_q;
        res_d.att   = att_q;
        res_d.suc   = suc_q;
        res_d.fail  = fail_q;
        res_d.unm   = unm_q;
        res_d.ovf   = ovf_q;
        st_d        = S_IDLE;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    prd_idx_q   <= prd_idx_d;
    hit_idx_q   <= hit_idx_d;
    free_idx_q  <= free_idx_d;
    hit_start_q <= hit_start_d;
    kind_q      <= kind_d;
    lat_q       <= lat_d;
    ovf_q       <= ovf_d;
    show_q      <= show_d;
    res_q       <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_INIT;
      cnt_q        <= '0;
      prd_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      used_q       <= '0;
      head_q       <= '0;
      fill_q       <= '0;
      att_q        <= '0;
      suc_q        <= '0;
      fail_q       <= '0;
      unm_q        <= '0;
      res_vld_q    <= 1'b0;
    end else begin
      st_q         <= st_d;
      cnt_q        <= cnt_d;
      prd_vld_q    <= prd_vld_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      used_q       <= used_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      att_q        <= att_d;
      suc_q        <= suc_d;
      fail_q       <= fail_d;
      unm_q        <= unm_d;
      res_vld_q    <= res_vld_d;
    end
  end

  assign init_busy_o = (st_q == S_INIT);
  assign res_vld_o   = res_vld_q;
  assign res_o       = res_q;

  `ASSERT_ALWAYS(a_used_bound, clk_i, rst_ni, used_q <= TCNT_W'(TABLE_DEPTH), "table overfilled")
  `ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, fill_q <= WCNT_W'(WINDOW_DEPTH), "ring overfilled")
  `ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, cmd_pop_o, st_q == S_IDLE && !res_vld_q, "bad cmd pop")
  `ASSERT_NEXT(a_fin_res, clk_i, rst_ni, st_q == S_FIN, res_vld_q, "result not posted")

endmodule

### hdl/tcp_handshake_latency_tracker_unit.sv
// top level of the tcp handshake latency tracker: apb register and wiring
// depends on tht_pkg, tht_front and tht_back
//
// Follows tcp connect attempts by four-tuple and returns one result beat per
// input beat, in order. Input and results are queue-style (push/full,
// empty/pop); a two-entry command queue lets new beats in while the engine
// works or a result waits. After reset the pending table is cleared by a
// pass over all TABLE_DEPTH (1024) entries, during which full stays high. Each
// state transition that starts or ends an attempt scans the whole pending
// table one entry a cycle; an insert that finds the table full clears it
// first, and a conclusion is logged in the window ring. Ignored transitions
// skip the scan; an aging tick reads the window ring through its registered
// read and drops the oldest entries while they are older than window_us.
// window_us sits at address 0.
module tcp_handshake_latency_tracker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [3:0]  old_state_i,
  input  logic [3:0]  new_state_i,
  input  logic [47:0] time_us_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [31:0] out_src_addr_o,
  output logic [31:0] out_dst_addr_o,
  output logic [15:0] out_src_port_o,
  output logic [15:0] out_dst_port_o,
  output logic [47:0] latency_us_o,
  output logic [31:0] attempt_total_o,
  output logic [31:0] success_total_o,
  output logic [31:0] failure_total_o,
  output logic [31:0] unmatched_total_o,
  output logic        overflow_o
);
  import tht_pkg::*;

  logic [31:0] window_q;
  logic        cmd_vld, cmd_pop, init_busy, res_vld;
  cmd_t        cmd;
  res_t        res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? window_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_US_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      window_q <= pwdata;
    end
  end

  tht_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .hold_i     (init_busy),
    .req_type_i (req_type_i),
    .src_addr_i (src_addr_i),
    .dst_addr_i (dst_addr_i),
    .src_port_i (src_port_i),
    .dst_port_i (dst_port_i),
    .old_state_i(old_state_i),
    .new_state_i(new_state_i),
    .time_us_i  (time_us_i),
    .cmd_vld_o  (cmd_vld),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  tht_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .window_us_i(window_q),
    .cmd_vld_i  (cmd_vld),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .init_busy_o(init_busy),
    .res_vld_o  (res_vld),
    .res_o      (res),
    .res_pop_i  (pop)
  );

  assign empty             = !res_vld;
  assign kind_o            = res.kind;
  assign out_src_addr_o    = res.addrs[63:32];
  assign out_dst_addr_o    = res.addrs[31:0];
  assign out_src_port_o    = res.ports[31:16];
  assign out_dst_port_o    = res.ports[15:0];
  assign latency_us_o      = res.lat;
  assign attempt_total_o   = res.att;
  assign success_total_o   = res.suc;
  assign failure_total_o   = res.fail;
  assign unmatched_total_o = res.unm;
  assign overflow_o        = res.ovf;

endmodule
